// ----- sv/fir_pkg.sv -----
// Shared constants and types of the FIR filter.
package fir_pkg;

    localparam int MAX_TAPS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TAP_BITS        = 16;
    localparam int FRAC_BITS       = 15;
    localparam int TAP_IDX_BITS    = 4;
    localparam int CFG_BITS        = 5;

    localparam logic [CFG_BITS-1:0] TAP_COUNT_RST = 5'd16;

    // Item kind carried on tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TAP    = 1'b1;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;    // zero the accumulator
        logic mul_en;   // operands valid this cycle
    } t_mac_ctrl;

endpackage

// ----- sv/fir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/fir_mac.sv -----
// Shared multiply-accumulate unit with output rounding and saturation.
module fir_mac #(
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_W       = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fir_pkg::t_mac_ctrl            i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [fir_pkg::TAP_BITS-1:0] i_tap,
    output logic                          o_busy,
    output logic [SAMPLE_BITS-1:0]        o_y,
    output logic                          o_sat
);
    import fir_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + TAP_BITS;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W:0]    rnd;
    logic signed [ACC_W:0]    y_full;
    logic [ACC_W-SAMPLE_BITS+1:0] hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.mul_en;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= i_sample * i_tap;
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, then floor-shift out the fraction
    always_comb begin
        rnd    = $signed({r_acc[ACC_W-1], r_acc})
               + $signed({{(ACC_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
        y_full = rnd >>> FRAC_BITS;
        hi     = y_full[ACC_W:SAMPLE_BITS-1];
        if ((&hi) || !(|hi)) begin
            o_y   = y_full[SAMPLE_BITS-1:0];
            o_sat = 1'b0;
        end else if (y_full[ACC_W]) begin
            o_y   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            o_sat = 1'b1;
        end else begin
            o_y   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            o_sat = 1'b1;
        end
    end

    assign o_busy = r_prod_vld;

endmodule

// ----- sv/fir_filter.sv -----
// Top level of the direct-form FIR filter with one shared multiply-accumulate.
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+------------------------------------
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata: sample, tap_index, tap_value
//            |     |                                | tuser: kind, tlast: first
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata: filtered, tuser: saturated
//  cfg       | in  | i_cfg_valid/o_cfg_ready         | i_cfg_data: tap_count
//
//  A sample item (tap_count clamped to 1..MAX_TAPS) writes the delay line, then
//  passes one tap per cycle through the shared multiplier, drains its pipeline
//  and loads the result. Tap items are taken without leaving the idle state.
//  Reset clears the delay line and the tap store through per-entry valid bits,
//  so the block is ready in the cycle after reset. A result waits in the output
//  register; a new item is taken meanwhile, and only the next result stalls.
module fir_filter #(
    parameter int MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // tdata, lowest bit up: sample, tap_index, tap_value, zero padding
    input  logic [((SAMPLE_BITS+fir_pkg::TAP_IDX_BITS+fir_pkg::TAP_BITS+7)/8)*8-1:0]
                 i_s_axis_tdata,
    // tuser: kind
    input  logic i_s_axis_tuser,
    // tlast: first sample of a block
    input  logic i_s_axis_tlast,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata, lowest bit up: filtered, zero padding
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // tuser: saturated
    output logic o_m_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fir_pkg::CFG_BITS-1:0]  i_cfg_data
);
    import fir_pkg::*;

    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ACC_W  = SAMPLE_BITS + TAP_BITS + AW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state                 r_state;
    logic [CFG_BITS-1:0]    r_tap_count;
    logic [AW-1:0]          r_wp;
    logic [AW-1:0]          r_ha;
    logic [AW-1:0]          r_k;
    logic [AW-1:0]          r_last;
    logic [MAX_TAPS-1:0]    r_hist_vld;
    logic [MAX_TAPS-1:0]    r_tap_vld;
    logic                   r_rd_vld;
    logic                   r_hv_q;
    logic                   r_tv_q;
    logic                   r_out_vld;
    logic [SAMPLE_BITS-1:0] r_out_data;
    logic                   r_out_sat;

    logic                       in_acc;
    logic                       smp_acc;
    logic                       tap_acc;
    logic                       tap_ok;
    logic [SAMPLE_BITS-1:0]     in_sample;
    logic [TAP_IDX_BITS-1:0]    in_tap_idx;
    logic [TAP_BITS-1:0]        in_tap_val;
    logic [AW-1:0]              tap_waddr;
    logic [AW-1:0]              n_wp;
    logic [AW-1:0]              n_m1;
    logic [AW-1:0]              ha_dec;
    logic [SAMPLE_BITS-1:0]     hist_rd;
    logic [TAP_BITS-1:0]        tap_rd;
    logic signed [SAMPLE_BITS-1:0] mac_sample;
    logic signed [TAP_BITS-1:0]    mac_tap;
    t_mac_ctrl                  mac_ctrl;
    logic                       mac_busy;
    logic [SAMPLE_BITS-1:0]     mac_y;
    logic                       mac_sat;
    logic                       out_free;
    logic                       issue;
    logic                       load_out;

    // Unpack the input item
    assign in_sample  = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_tap_idx = i_s_axis_tdata[SAMPLE_BITS+TAP_IDX_BITS-1:SAMPLE_BITS];
    assign in_tap_val = i_s_axis_tdata[SAMPLE_BITS+TAP_IDX_BITS+TAP_BITS-1:
                                       SAMPLE_BITS+TAP_IDX_BITS];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign smp_acc = in_acc && (i_s_axis_tuser == KIND_SAMPLE);
    assign tap_acc = in_acc && (i_s_axis_tuser == KIND_TAP);
    // Drop tap writes beyond the store
    assign tap_ok    = (32'(in_tap_idx) < MAX_TAPS);
    assign tap_waddr = AW'(in_tap_idx);

    // Newest sample goes one slot ahead in the circular delay line
    assign n_wp   = (r_wp == AW'(MAX_TAPS - 1)) ? '0 : r_wp + AW'(1);
    // Older samples sit at descending addresses
    assign ha_dec = (r_ha == '0) ? AW'(MAX_TAPS - 1) : r_ha - AW'(1);

    // Clamp the tap count to 1..MAX_TAPS; hold the index of the last tap
    always_comb begin
        if (r_tap_count == '0) begin
            n_m1 = '0;
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            n_m1 = AW'(MAX_TAPS - 1);
        end else begin
            n_m1 = AW'(r_tap_count - CFG_BITS'(1));
        end
    end

    assign issue    = (r_state == S_RUN);
    assign out_free = !r_out_vld || i_m_axis_tready;
    // Pipeline empty and output slot free: load the result
    assign load_out = (r_state == S_DRAIN) && !r_rd_vld && !mac_busy && out_free;

    fir_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (smp_acc),
        .i_waddr (n_wp),
        .i_wdata (in_sample),
        .i_raddr (r_ha),
        .o_rdata (hist_rd)
    );

    fir_ram #(
        .WIDTH (TAP_BITS),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_acc && tap_ok),
        .i_waddr (tap_waddr),
        .i_wdata (in_tap_val),
        .i_raddr (r_k),
        .o_rdata (tap_rd)
    );

    // Entries never written since reset (delay-line entries also since a block start) read as zero
    assign mac_sample = r_hv_q ? $signed(hist_rd) : '0;
    assign mac_tap    = r_tv_q ? $signed(tap_rd)  : '0;

    assign mac_ctrl.clear  = smp_acc;
    assign mac_ctrl.mul_en = r_rd_vld;

    fir_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_sample (mac_sample),
        .i_tap    (mac_tap),
        .o_busy   (mac_busy),
        .o_y      (mac_y),
        .o_sat    (mac_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap_count <= TAP_COUNT_RST;
            r_wp        <= '0;
            r_hist_vld  <= '0;
            r_tap_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tap_count <= i_cfg_data;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            // Flag read data returning from both stores next cycle
            r_rd_vld <= issue;
            if (issue) begin
                r_hv_q <= r_hist_vld[r_ha];
                r_tv_q <= r_tap_vld[r_k];
            end
            if (tap_acc && tap_ok) begin
                r_tap_vld[tap_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (smp_acc) begin
                        r_wp <= n_wp;
                        // A block start forgets all earlier samples
                        if (i_s_axis_tlast) begin
                            r_hist_vld <= MAX_TAPS'(1) << n_wp;
                        end else begin
                            r_hist_vld <= r_hist_vld | (MAX_TAPS'(1) << n_wp);
                        end
                        r_ha    <= n_wp;
                        r_k     <= '0;
                        r_last  <= n_m1;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_ha <= ha_dec;
                    r_k  <= r_k + AW'(1);
                    if (r_k == r_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // Wait for the pipeline to empty and the output slot to free
                    if (load_out) begin
                        r_out_data <= mac_y;
                        r_out_sat  <= mac_sat;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);
    assign o_m_axis_tuser  = r_out_sat;
    assign o_cfg_ready     = 1'b1;

endmodule

// ----- sv/fir_chk.sv -----
// Port-level checker for the FIR filter, bound to the top level.
module fir_chk #(
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic [((SAMPLE_BITS+fir_pkg::TAP_IDX_BITS+fir_pkg::TAP_BITS+7)/8)*8-1:0]
                i_s_axis_tdata,
    input logic i_s_axis_tuser,
    input logic i_s_axis_tlast,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input logic o_m_axis_tuser,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic i_cfg_valid,
    input logic o_cfg_ready,
    input logic [fir_pkg::CFG_BITS-1:0] i_cfg_data
);
    import fir_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    // No result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A sample item occupies the block
    a_smp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == KIND_SAMPLE))
            |=> !o_s_axis_tready)
        else $error("ready right after a sample item");

    // A tap item leaves the block ready
    a_tap_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == KIND_TAP))
            |=> o_s_axis_tready)
        else $error("not ready after a tap item");

    // A clipped result sits at one end of the range
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            ((o_m_axis_tdata[SAMPLE_BITS-1:0] == Y_MAX) ||
             (o_m_axis_tdata[SAMPLE_BITS-1:0] == Y_MIN)))
        else $error("saturated result off the rails");

endmodule

bind fir_filter fir_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_fir_chk (.*);

// ----- tb/fir_checker.sv -----
// Scoreboard for the FIR filter: predicts each output item and compares it.
module fir_checker #(
    parameter int IN_W  = ((fir_pkg::SAMPLE_BITS_DEF + fir_pkg::TAP_IDX_BITS
                            + fir_pkg::TAP_BITS + 7) / 8) * 8,
    parameter int OUT_W = ((fir_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // tdata, lowest bit up: sample, tap_index, tap_value, zero padding
    input  logic [IN_W-1:0]              i_s_tdata,
    // tuser: kind
    input  logic                         i_s_tuser,
    // tlast: first sample of a block
    input  logic                         i_s_tlast,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    // tdata, lowest bit up: filtered, zero padding
    input  logic [OUT_W-1:0]             i_m_tdata,
    // tuser: saturated
    input  logic                         i_m_tuser,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [fir_pkg::CFG_BITS-1:0] i_cfg_data,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    import fir_pkg::*;

    localparam int SB     = SAMPLE_BITS_DEF;
    localparam int IDX_LO = SB;
    localparam int VAL_LO = SB + TAP_IDX_BITS;

    typedef struct packed {
        logic signed [SB-1:0] filtered;
        logic                 saturated;
    } t_fir_out;

    logic signed [SB-1:0]       history [MAX_TAPS_DEF];
    logic signed [TAP_BITS-1:0] coeffs  [MAX_TAPS_DEF];
    logic [CFG_BITS-1:0]        taps_in_use;
    t_fir_out                   expected_outputs [$];
    int                         errors;
    int                         checked;
    int                         clipped;

    // Direct-form sum over the taps in use, rounded half up and clipped to the sample range.
    function automatic t_fir_out filter_sample();
        int       n;
        longint   acc;
        longint   y;
        t_fir_out r;
        n = (taps_in_use == 0) ? 1 :
            (taps_in_use > MAX_TAPS_DEF) ? MAX_TAPS_DEF : int'(taps_in_use);
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += longint'(coeffs[k]) * longint'(history[k]);
        y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r.saturated = 1'b0;
        if (y > 32767) begin
            y = 32767;
            r.saturated = 1'b1;
        end else if (y < -32768) begin
            y = -32768;
            r.saturated = 1'b1;
        end
        r.filtered = y[SB-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fir_out want;
        t_fir_out got;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TAPS_DEF; k++) begin
                history[k] = '0;
                coeffs[k]  = '0;
            end
            taps_in_use = TAP_COUNT_RST;
            expected_outputs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                taps_in_use = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == KIND_TAP) begin
                    // the first flag means nothing on a tap item
                    coeffs[i_s_tdata[IDX_LO +: TAP_IDX_BITS]] = i_s_tdata[VAL_LO +: TAP_BITS];
                end else begin
                    if (i_s_tlast)
                        for (int k = 0; k < MAX_TAPS_DEF; k++) history[k] = '0;
                    for (int k = MAX_TAPS_DEF - 1; k > 0; k--) history[k] = history[k-1];
                    history[0] = i_s_tdata[SB-1:0];
                    expected_outputs.push_back(filter_sample());
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.filtered  = i_m_tdata[SB-1:0];
                got.saturated = i_m_tuser;
                if (expected_outputs.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: output item %0d (sat %0b) arrived with nothing expected",
                                 $realtime, got.filtered, got.saturated);
                end else begin
                    want = expected_outputs.pop_front();
                    checked++;
                    if (want.saturated) clipped++;
                    if (got.filtered !== want.filtered || got.saturated !== want.saturated) begin
                        errors++;
                        if (errors <= 10)
                            $display("%t: output %0d: filtered exp %0d got %0d, sat exp %0b got %0b",
                                     $realtime, checked, want.filtered, got.filtered,
                                     want.saturated, got.saturated);
                    end
                end
            end
        end
        // publish through nonblocking updates so readers at this edge see settled values
        o_errors  <= errors;
        o_pending <= expected_outputs.size();
        o_checked <= checked;
        o_clipped <= clipped;
    end

    initial begin
        errors    = 0;
        checked   = 0;
        clipped   = 0;
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        o_clipped = 0;
    end

endmodule

// ----- tb/tb_fir_filter.sv -----
// Top of the FIR filter testbench: clock, reset, stimulus, receiver and verdict.
module tb_fir_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import fir_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int IN_W        = ((SB + TAP_IDX_BITS + TAP_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((SB + 7) / 8) * 8;
    localparam int DRAIN       = MAX_TAPS_DEF + 8;
    localparam int HOLD_CYCLES = 700;
    localparam int PHASE_ITEMS = 120;
    localparam int LIMIT       = 600000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                s_tuser = KIND_SAMPLE;
    logic                s_tlast = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data = TAP_COUNT_RST;

    int errors;
    int pending;
    int checked;
    int clipped;
    int cycles = 0;
    int samples_sent = 0;
    int taps_sent = 0;
    int cfg_writes = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit hold_request = 1'b0;

    always #4ns i_clk = ~i_clk;

    fir_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    fir_checker scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_clipped   (clipped)
    );

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until the block takes it.
    // Valid stays high on return so a back-to-back item follows without a gap.
    task automatic offer_item(input logic kind, input logic [SB-1:0] sample,
                              input logic first, input logic [TAP_IDX_BITS-1:0] idx,
                              input logic [TAP_BITS-1:0] coeff);
        logic [IN_W-1:0] word;
        int              gap;
        word = '0;
        word[SB-1:0] = sample;
        word[SB +: TAP_IDX_BITS] = idx;
        word[SB + TAP_IDX_BITS +: TAP_BITS] = coeff;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= word;
        s_tuser  <= kind;
        s_tlast  <= first;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    endtask

    // Unused fields carry noise: the block must ignore them.
    task automatic send_sample(input logic [SB-1:0] sample, input logic first);
        offer_item(KIND_SAMPLE, sample, first, TAP_IDX_BITS'($urandom), TAP_BITS'($urandom));
        samples_sent++;
    endtask

    task automatic send_tap(input logic [TAP_IDX_BITS-1:0] idx, input logic [TAP_BITS-1:0] coeff);
        offer_item(KIND_TAP, SB'($urandom), 1'($urandom_range(0, 1)), idx, coeff);
        taps_sent++;
    endtask

    // Lean towards the extremes and small values, else full range.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 64) - 32);
            3:       return 16'($urandom_range(0, 4096) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    // Drop valid, let the last accept reach the scoreboard, wait for every
    // expected output, then let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_tap_count(input logic [CFG_BITS-1:0] value);
        wait_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Receiver: random stalls, bursts of ready, and one long hold-off on request.
    initial begin : receiver
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = rx_burst ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        end
    end

    initial begin : stimulus
        logic [CFG_BITS-1:0] plan [10];
        int                  r;
        plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd2, 5'd15, 5'd0, 5'd0, 5'd8};
        plan[7] = CFG_BITS'($urandom_range(1, 16));
        plan[8] = CFG_BITS'($urandom_range(1, 16));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: taps are zero after reset, so the first output must be zero.
        send_sample(16'd1000, 1'b1);
        send_tap(4'd0, 16'h7FFF);
        send_tap(4'd1, 16'h8000);
        send_tap(4'd7, 16'hFFFF);
        send_tap(4'd15, 16'h4000);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        // most negative tap times most negative sample clips high
        send_tap(4'd0, 16'h8000);
        send_sample(16'h8000, 1'b1);
        // two negative taps on full-scale positive samples clip low
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        // fill the history past tap 7, then restart mid-stream
        for (int k = 0; k < 8; k++) send_sample(pick_value(), 1'b0);
        send_sample(16'h1234, 1'b1);

        // Random phases, each under its own tap count, extremes and out-of-range among them.
        for (int p = 0; p < 10; p++) begin
            write_tap_count(plan[p]);
            if ($urandom_range(0, 1) == 0)
                for (int k = 0; k < MAX_TAPS_DEF; k++) send_tap(k[TAP_IDX_BITS-1:0], pick_value());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == 40) hold_request = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 12)
                    send_tap(TAP_IDX_BITS'($urandom), pick_value());
                else
                    send_sample(pick_value(), r < 17);
            end
        end

        wait_idle();
        $display("Sent %0d samples and %0d tap writes over %0d tap-count settings.",
                 samples_sent, taps_sent, cfg_writes);
        $display("Checked %0d outputs, %0d of them clipped, %0d mismatches.",
                 checked, clipped, errors);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
